// File: src/max_height_pyramid_store_unit_assert.svh
`ifndef MAX_HEIGHT_PYRAMID_STORE_UNIT_ASSERT_SVH
`define MAX_HEIGHT_PYRAMID_STORE_UNIT_ASSERT_SVH

// Implication checked on the same edge.
`define MHPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked on the following edge.
`define MHPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mhps_pkg.sv
package mhps_pkg;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ADDR,
      S_DATA,
      S_STAT,
      S_MIP,
      S_DONE
   } state_type;

   localparam logic [2:0] CMD_WRITE   = 3'd0;
   localparam logic [2:0] CMD_RAISE   = 3'd1;
   localparam logic [2:0] CMD_REBUILD = 3'd2;
   localparam logic [2:0] CMD_READ    = 3'd3;
   localparam logic [2:0] CMD_CLEAR   = 3'd4;

   localparam logic [1:0] REG_FIELD_VALID = 2'd0;
   localparam logic [1:0] REG_ANCHOR_X    = 2'd1;
   localparam logic [1:0] REG_ANCHOR_Y    = 2'd2;
   localparam logic [1:0] REG_MIP_LEVELS  = 2'd3;

   localparam logic [31:0] POS_INF = 32'h7F80_0000;
   localparam logic [31:0] NEG_INF = 32'hFF80_0000;

   function automatic logic is_nan(logic [31:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
   endfunction

   function automatic logic [31:0] ord_key(logic [31:0] b);
      return b[31] ? ~b : (b | 32'h8000_0000);
   endfunction

   // Float a <= b; false when either is NaN.
   function automatic logic fle(logic [31:0] a, logic [31:0] b);
      return !is_nan(a) && !is_nan(b) &&
             (((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) || (ord_key(a) <= ord_key(b)));
   endfunction

   function automatic logic [31:0] fmax(logic [31:0] a, logic [31:0] b);
      return fle(b, a) ? a : b;
   endfunction

   function automatic logic [31:0] fmin(logic [31:0] a, logic [31:0] b);
      return fle(a, b) ? a : b;
   endfunction

endpackage

// File: src/mhps_ram.sv
module mhps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: src/max_height_pyramid_store_unit.sv
// Channel  Direction  Handshake                Word
// req      in         req_tvalid/req_tready    command, cell_x, cell_y, level, value
// rsp      out        rsp_tvalid/rsp_tready    read_value, in_field, counts, min, max
// csr      in         csr_valid/csr_ready      register index and data
//
// Write and an out-of-field read or raise pass through the address and done states to idle.
// An in-field raise or read also visits the data state, since the memory read is registered.
// Rebuild scans every leaf, then builds each coarse cell from four reads and one write.
// Clear walks the whole store, one entry per cycle.
// After reset the same walk fills the store before the first word is taken.
// A result that is not taken holds the block in its final state.
`include "max_height_pyramid_store_unit_assert.svh"

module max_height_pyramid_store_unit #(
   parameter int FIELD_DIM  = 256,
   parameter int MAX_LEVELS = 9
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[2:0], cell_x[34:3], cell_y[66:35], level[70:67], value[102:71], zero pad
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // read_value[31:0], in_field[32], infinite_count[49:33], min_height[81:50],
   // max_height[113:82], zero pad
   output logic [119:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   function automatic int store_depth();
      int s;
      s = 0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
         s += (FIELD_DIM >> k) * (FIELD_DIM >> k);
      end
      return s;
   endfunction

   localparam int LOG_DIM = $clog2(FIELD_DIM);
   localparam int LEAVES  = FIELD_DIM * FIELD_DIM;
   localparam int DEPTH   = store_depth();
   localparam int AW      = $clog2(DEPTH);
   localparam int CW      = AW + 1;
   localparam int DW      = LOG_DIM + 1;

   function automatic logic [AW-1:0] level_base(logic [3:0] m);
      logic [AW-1:0] acc;
      acc = '0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
         if (k < int'(m)) begin
            acc = acc + AW'((FIELD_DIM >> k) * (FIELD_DIM >> k));
         end
      end
      return acc;
   endfunction

   mhps_pkg::state_type state_ff, state_in;

   logic        field_valid_ff;
   logic [31:0] anchor_x_ff, anchor_y_ff;
   logic [3:0]  mip_levels_ff;
   logic [3:0]  lv;

   logic [2:0]  cmd_ff;
   logic [31:0] cx_ff, cy_ff, val_ff;
   logic [3:0]  lvl_ff;

   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          clr_rsp_ff, clr_rsp_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] infs_ff, infs_in;
   logic [31:0]   lo_ff, lo_in, hi_ff, hi_in;

   logic [3:0]         m_ff, m_in;
   logic [LOG_DIM-1:0] x_ff, x_in, y_ff, y_in;
   logic [AW-1:0]      src_ff, src_in, dst_ff, dst_in, lbase_ff, lbase_in;
   logic [2:0]         k_ff, k_in;
   logic [31:0]        a_ff, a_in, c_ff, c_in;

   logic [31:0] res_rv_ff, res_rv_in;
   logic        res_in_ff, res_in_in;
   logic [16:0] res_cnt_ff, res_cnt_in;
   logic [31:0] res_min_ff, res_min_in, res_max_ff, res_max_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [119:0] rsp_data_ff;
   logic         rsp_load;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data;

   logic [3:0]    lvl_use;
   logic [32:0]   lx, ly;
   logic [31:0]   sx, sy, dim_a;
   logic          in_cell;
   logic [AW-1:0] idx_a;
   logic [DW-1:0] dim_m, dim_n;
   logic [AW-1:0] pd;
   logic          x_last, y_last, finite;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_valid_ff <= 1'b0;
         anchor_x_ff    <= '0;
         anchor_y_ff    <= '0;
         mip_levels_ff  <= 4'd6;
      end else if (csr_valid) begin
         unique case (csr_index)
            mhps_pkg::REG_FIELD_VALID: field_valid_ff <= csr_data[0];
            mhps_pkg::REG_ANCHOR_X:    anchor_x_ff    <= csr_data;
            mhps_pkg::REG_ANCHOR_Y:    anchor_y_ff    <= csr_data;
            mhps_pkg::REG_MIP_LEVELS:  mip_levels_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   assign lv = (mip_levels_ff == 4'd0) ? 4'd1 :
               (mip_levels_ff > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : mip_levels_ff;

   assign req_tready = (state_ff == mhps_pkg::S_IDLE);

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff <= req_tdata[2:0];
         cx_ff  <= req_tdata[34:3];
         cy_ff  <= req_tdata[66:35];
         lvl_ff <= req_tdata[70:67];
         val_ff <= req_tdata[102:71];
      end
   end

   assign lvl_use = (cmd_ff == mhps_pkg::CMD_READ) ? lvl_ff : 4'd0;
   assign lx      = {cx_ff[31], cx_ff} - {anchor_x_ff[31], anchor_x_ff};
   assign ly      = {cy_ff[31], cy_ff} - {anchor_y_ff[31], anchor_y_ff};
   assign sx      = lx[31:0] >> lvl_use;
   assign sy      = ly[31:0] >> lvl_use;
   assign dim_a   = 32'(FIELD_DIM) >> lvl_use;
   assign in_cell = !lx[32] && !ly[32] && (sx < dim_a) && (sy < dim_a) && (lvl_use < lv);
   assign idx_a   = level_base(lvl_use) + (AW'(sy) << (4'(LOG_DIM) - lvl_use)) + AW'(sx);

   assign dim_m  = DW'(FIELD_DIM) >> m_ff;
   assign dim_n  = DW'(FIELD_DIM) >> (m_ff + 4'd1);
   assign pd     = AW'(dim_m) << 1;
   assign x_last = (DW'(x_ff) == dim_m - DW'(1));
   assign y_last = (DW'(y_ff) == dim_m - DW'(1));
   assign finite = !mhps_pkg::is_nan(rd_data) && (rd_data != mhps_pkg::POS_INF);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mhps_pkg::S_CLEAR;
         cnt_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         clr_rsp_ff <= clr_rsp_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      infs_ff    <= infs_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      m_ff       <= m_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      lbase_ff   <= lbase_in;
      k_ff       <= k_in;
      a_ff       <= a_in;
      c_ff       <= c_in;
      res_rv_ff  <= res_rv_in;
      res_in_ff  <= res_in_in;
      res_cnt_ff <= res_cnt_in;
      res_min_ff <= res_min_in;
      res_max_ff <= res_max_in;
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      clr_rsp_in = clr_rsp_ff;
      pend_in    = 1'b0;
      idx_in     = idx_ff;
      infs_in    = infs_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      m_in       = m_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      lbase_in   = lbase_ff;
      k_in       = k_ff;
      a_in       = a_ff;
      c_in       = c_ff;
      res_rv_in  = res_rv_ff;
      res_in_in  = res_in_ff;
      res_cnt_in = res_cnt_ff;
      res_min_in = res_min_ff;
      res_max_in = res_max_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = mhps_pkg::POS_INF;
      rd_en      = 1'b0;
      rd_addr    = '0;
      rsp_load   = 1'b0;

      unique case (state_ff)
         mhps_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[AW-1:0];
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DEPTH - 1)) begin
               state_in = clr_rsp_ff ? mhps_pkg::S_DONE : mhps_pkg::S_IDLE;
            end
         end
         mhps_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = mhps_pkg::S_ADDR;
            end
         end
         mhps_pkg::S_ADDR: begin
            res_rv_in  = '0;
            res_in_in  = 1'b0;
            res_cnt_in = '0;
            res_min_in = '0;
            res_max_in = '0;
            idx_in     = idx_a;
            state_in   = mhps_pkg::S_DONE;
            case (cmd_ff)
               mhps_pkg::CMD_WRITE: begin
                  if (field_valid_ff && in_cell) begin
                     wr_en   = 1'b1;
                     wr_addr = idx_a;
                     wr_data = val_ff;
                  end
               end
               mhps_pkg::CMD_RAISE: begin
                  if (field_valid_ff && in_cell) begin
                     rd_en    = 1'b1;
                     rd_addr  = idx_a;
                     state_in = mhps_pkg::S_DATA;
                  end
               end
               mhps_pkg::CMD_READ: begin
                  if (in_cell) begin
                     rd_en    = 1'b1;
                     rd_addr  = idx_a;
                     state_in = mhps_pkg::S_DATA;
                  end else begin
                     res_rv_in = mhps_pkg::POS_INF;
                  end
               end
               mhps_pkg::CMD_REBUILD: begin
                  if (field_valid_ff) begin
                     cnt_in   = '0;
                     infs_in  = '0;
                     lo_in    = mhps_pkg::POS_INF;
                     hi_in    = mhps_pkg::NEG_INF;
                     state_in = mhps_pkg::S_STAT;
                  end
               end
               mhps_pkg::CMD_CLEAR: begin
                  cnt_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = mhps_pkg::S_CLEAR;
               end
               default: ;
            endcase
         end
         mhps_pkg::S_DATA: begin
            state_in = mhps_pkg::S_DONE;
            if (cmd_ff == mhps_pkg::CMD_READ) begin
               res_rv_in = rd_data;
               res_in_in = 1'b1;
            end else if (!mhps_pkg::fle(val_ff, rd_data)) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = val_ff;
            end
         end
         mhps_pkg::S_STAT: begin
            if (cnt_ff != CW'(LEAVES)) begin
               rd_en   = 1'b1;
               rd_addr = cnt_ff[AW-1:0];
               cnt_in  = cnt_ff + CW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (finite) begin
                  lo_in = mhps_pkg::fmin(lo_ff, rd_data);
                  hi_in = mhps_pkg::fmax(hi_ff, rd_data);
               end else begin
                  infs_in = infs_ff + CW'(1);
               end
            end
            if ((cnt_ff == CW'(LEAVES)) && !pend_ff) begin
               res_cnt_in = infs_ff[16:0];
               res_min_in = (infs_ff == CW'(LEAVES)) ? 32'd0 : lo_ff;
               res_max_in = (infs_ff == CW'(LEAVES)) ? 32'd0 : hi_ff;
               m_in       = 4'd1;
               x_in       = '0;
               y_in       = '0;
               k_in       = '0;
               src_in     = '0;
               dst_in     = AW'(LEAVES);
               lbase_in   = AW'(LEAVES);
               state_in   = (lv > 4'd1) ? mhps_pkg::S_MIP : mhps_pkg::S_DONE;
            end
         end
         mhps_pkg::S_MIP: begin
            k_in = k_ff + 3'd1;
            if (k_ff != 3'd4) begin
               rd_en   = 1'b1;
               rd_addr = src_ff + (k_ff[1] ? pd : AW'(0)) + AW'(k_ff[0]);
            end
            case (k_ff)
               3'd1: a_in = rd_data;
               3'd2: a_in = mhps_pkg::fmax(a_ff, rd_data);
               3'd3: c_in = rd_data;
               default: ;
            endcase
            if (k_ff == 3'd4) begin
               wr_en   = 1'b1;
               wr_addr = dst_ff;
               wr_data = mhps_pkg::fmax(a_ff, mhps_pkg::fmax(c_ff, rd_data));
               k_in    = '0;
               dst_in  = dst_ff + AW'(1);
               if (!x_last) begin
                  x_in   = x_ff + LOG_DIM'(1);
                  src_in = src_ff + AW'(2);
               end else if (!y_last) begin
                  x_in   = '0;
                  y_in   = y_ff + LOG_DIM'(1);
                  src_in = src_ff + pd + AW'(2);
               end else begin
                  x_in     = '0;
                  y_in     = '0;
                  m_in     = m_ff + 4'd1;
                  src_in   = lbase_ff;
                  lbase_in = dst_ff + AW'(1);
                  if ((m_ff + 4'd1 >= lv) || (dim_n == DW'(0))) begin
                     state_in = mhps_pkg::S_DONE;
                  end
               end
            end
         end
         mhps_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load   = 1'b1;
               clr_rsp_in = 1'b0;
               state_in   = mhps_pkg::S_IDLE;
            end
         end
         default: state_in = mhps_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {6'd0, res_max_ff, res_min_ff, res_cnt_ff, res_in_ff, res_rv_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   mhps_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   `MHPS_ASSERT_NEXT(a_accept_addr, clock, reset, req_tvalid && req_tready, state_ff == mhps_pkg::S_ADDR, "accepted word did not reach address stage")
   `MHPS_ASSERT_SAME(a_idle_no_write, clock, reset, state_ff == mhps_pkg::S_IDLE, !wr_en && !rd_en, "store accessed while idle")
   `MHPS_ASSERT_SAME(a_mip_step, clock, reset, state_ff == mhps_pkg::S_MIP, k_ff <= 3'd4, "mip step counter out of range")
   `MHPS_ASSERT_NEXT(a_load_valid, clock, reset, rsp_load, rsp_tvalid, "loaded result not presented")

endmodule
